/* rtl/tpgoc_pkg.sv */
// Shared types, constants and arithmetic helpers for the touch grid offset correction.
package tpgoc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_X_SPLITS  = 3'd0;
   localparam logic [2:0] CSR_Y_SPLITS  = 3'd1;
   localparam logic [2:0] CSR_ROW_TOP   = 3'd2;
   localparam logic [2:0] CSR_ROW_MID   = 3'd3;
   localparam logic [2:0] CSR_ROW_BOT   = 3'd4;

   // Depth of the queue between the classifier and the datapath.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
   localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

   typedef struct packed {
      logic [15:0] x_in;
      logic [15:0] y_in;
      logic        is_finger;
   } req_type;

   typedef struct packed {
      logic [15:0] x_out;
      logic [15:0] y_out;
      logic        corrected;
   } rsp_type;

   // A classified request: area bounds, distances and the corner offsets.
   // ox and oy hold: top-left, top-right, bottom-left, bottom-right corners.
   typedef struct packed {
      logic               pass;
      logic [15:0]        x;
      logic [15:0]        y;
      logic [15:0]        bxp;
      logic signed [16:0] nx;
      logic signed [16:0] sx;
      logic signed [16:0] ny;
      logic signed [16:0] sy;
      logic [3:0][15:0]   ox;
      logic [3:0][15:0]   oy;
   } item_type;

   // Context that travels with a request down the datapath.
   typedef struct packed {
      item_type           it;
      logic signed [31:0] pq;
      logic signed [31:0] rs;
      logic signed [31:0] cx;
      logic signed [31:0] ty;
      logic [1:0]         qneg;
   } ctx_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Saturate a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

   // Magnitude of a signed 50-bit value.
   function automatic logic [49:0] mag50(input logic signed [49:0] v);
      logic [49:0] r;
      r = v[49] ? 50'(-v) : 50'(v);
      return r;
   endfunction

   // Magnitude of a signed 17-bit span, which always fits 16 bits.
   function automatic logic [15:0] mag17(input logic signed [16:0] v);
      logic [16:0] r;
      r = v[16] ? 17'(-v) : 17'(v);
      return r[15:0];
   endfunction

   // Give a quotient magnitude its sign.
   function automatic logic signed [49:0] apply_sign(input logic neg, input logic [47:0] mag);
      logic signed [49:0] m;
      m = $signed({2'b00, mag});
      return neg ? -m : m;
   endfunction

   // Grid node offset for a row in -1..3 and a column in -1..2.
   // The x offset is zero beyond the left and right borders and carried along
   // the top and bottom; the y offset the other way round.
   function automatic logic signed [15:0] node_off(input logic [2:0][63:0] rows,
                                                   input logic signed [3:0] row,
                                                   input logic signed [3:0] col,
                                                   input logic axis);
      logic signed [3:0] rr;
      logic signed [3:0] cc;
      logic              zero;
      logic [63:0]       w;
      logic [15:0]       f;
      rr   = row;
      cc   = col;
      zero = 1'b0;
      if (!axis) begin
         if (col < 4'sd0 || col > 4'sd1) zero = 1'b1;
         if (rr < 4'sd0) rr = 4'sd0;
         if (rr > 4'sd2) rr = 4'sd2;
      end else begin
         if (row < 4'sd0 || row > 4'sd2) zero = 1'b1;
         if (cc < 4'sd0) cc = 4'sd0;
         if (cc > 4'sd1) cc = 4'sd1;
      end
      if (rr[1:0] == 2'd2) begin
         w = rows[2];
      end else if (rr[1:0] == 2'd1) begin
         w = rows[1];
      end else begin
         w = rows[0];
      end
      unique case ({cc[0], axis})
         2'b00: f = w[15:0];
         2'b01: f = w[31:16];
         2'b10: f = w[47:32];
         default: f = w[63:48];
      endcase
      return zero ? 16'sd0 : $signed(f);
   endfunction

endpackage

/* rtl/touch_position_grid_offset_correction.sv */
// Top level of the touch position grid offset correction block.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  req_data  (x_in, y_in, is_finger)
//   rsp_      out        rsp_valid / rsp_ready  rsp_data  (x_out, y_out, corrected)
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// One request is accepted per cycle while the queue has room; a result passes through
// the four chained dividers (32, 48, 48 and 48 stages) and the multiply and correction
// stages between them.
// Reset is synchronous and clears all configuration registers, the queue and valids.
// A stalled result holds the whole datapath; the four-entry queue keeps taking
// requests until it fills.
module touch_position_grid_offset_correction #(
   parameter int PANEL_WIDTH    = 1080,
   parameter int PANEL_HEIGHT   = 1920,
   parameter int DISPLAY_WIDTH  = 1080,
   parameter int DISPLAY_HEIGHT = 1920,
   parameter int CANCEL_X       = 9999,
   parameter int CANCEL_Y       = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tpgoc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tpgoc_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import tpgoc_pkg::*;

   item_type   front_item;
   item_type   head_item;
   q_stat_type q_stat;
   logic       advance;
   logic       push;
   logic       pop;

   tpgoc_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .CANCEL_X     (CANCEL_X),
      .CANCEL_Y     (CANCEL_Y)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .item      (front_item)
   );

   // A request enters the queue whenever there is room.
   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;
   assign pop       = advance && !q_stat.empty;

   tpgoc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   tpgoc_back #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_stat.empty),
      .in_item   (head_item),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/tpgoc_front.sv */
// Configuration registers and request classifier: pass-through test, area and corner offsets.
module tpgoc_front #(
   parameter int PANEL_WIDTH  = 1080,
   parameter int PANEL_HEIGHT = 1920,
   parameter int CANCEL_X     = 9999,
   parameter int CANCEL_Y     = 9999
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata,
   input  tpgoc_pkg::req_type  req_data,
   output tpgoc_pkg::item_type item
);
   import tpgoc_pkg::*;

   logic [31:0]      x_splits_ff;
   logic [47:0]      y_splits_ff;
   logic [2:0][63:0] rows_ff;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_splits_ff <= '0;
         y_splits_ff <= '0;
         rows_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_SPLITS: x_splits_ff <= csr_wdata[31:0];
            CSR_Y_SPLITS: y_splits_ff <= csr_wdata[47:0];
            CSR_ROW_TOP:  rows_ff[0]  <= csr_wdata;
            CSR_ROW_MID:  rows_ff[1]  <= csr_wdata;
            CSR_ROW_BOT:  rows_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0]       xs0, xs1, ys0, ys1, ys2, x, y;
   logic [15:0]       bxq, byp, byq;
   logic [1:0]        c, r;
   logic signed [3:0] rm1, rr, cm1, cc;

   // Area choice and corner values for the request on the input port.
   always_comb begin
      xs0 = x_splits_ff[15:0];
      xs1 = x_splits_ff[31:16];
      ys0 = y_splits_ff[15:0];
      ys1 = y_splits_ff[31:16];
      ys2 = y_splits_ff[47:32];
      x   = req_data.x_in;
      y   = req_data.y_in;

      item      = '0;
      item.x    = x;
      item.y    = y;
      item.pass = (xs0 == 16'd0) || !req_data.is_finger ||
                  (x == 16'(CANCEL_X) && y == 16'(CANCEL_Y));

      priority if (x < xs0) c = 2'd0;
      else if (x < xs1)     c = 2'd1;
      else                  c = 2'd2;

      priority if (y < ys0) r = 2'd0;
      else if (y < ys1)     r = 2'd1;
      else if (y < ys2)     r = 2'd2;
      else                  r = 2'd3;

      unique case (c)
         2'd0: begin
            item.bxp = 16'd0;
            bxq      = xs0;
         end
         2'd1: begin
            item.bxp = xs0;
            bxq      = xs1;
         end
         default: begin
            item.bxp = xs1;
            bxq      = 16'(PANEL_WIDTH);
         end
      endcase

      unique case (r)
         2'd0: begin
            byp = 16'd0;
            byq = ys0;
         end
         2'd1: begin
            byp = ys0;
            byq = ys1;
         end
         2'd2: begin
            byp = ys1;
            byq = ys2;
         end
         default: begin
            byp = ys2;
            byq = 16'(PANEL_HEIGHT);
         end
      endcase

      item.nx = $signed({1'b0, x}) - $signed({1'b0, item.bxp});
      item.sx = $signed({1'b0, bxq}) - $signed({1'b0, item.bxp});
      item.ny = $signed({1'b0, y}) - $signed({1'b0, byp});
      item.sy = $signed({1'b0, byq}) - $signed({1'b0, byp});

      rr  = $signed({2'b00, r});
      rm1 = rr - 4'sd1;
      cc  = $signed({2'b00, c});
      cm1 = cc - 4'sd1;

      item.ox[0] = node_off(rows_ff, rm1, cm1, 1'b0);
      item.ox[1] = node_off(rows_ff, rm1, cc,  1'b0);
      item.ox[2] = node_off(rows_ff, rr,  cm1, 1'b0);
      item.ox[3] = node_off(rows_ff, rr,  cc,  1'b0);
      item.oy[0] = node_off(rows_ff, rm1, cm1, 1'b1);
      item.oy[1] = node_off(rows_ff, rm1, cc,  1'b1);
      item.oy[2] = node_off(rows_ff, rr,  cm1, 1'b1);
      item.oy[3] = node_off(rows_ff, rr,  cc,  1'b1);
   end

endmodule

/* rtl/tpgoc_queue.sv */
// Short queue of classified requests between the classifier and the datapath.
module tpgoc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tpgoc_pkg::item_type   push_item,
   input  logic                  pop,
   output tpgoc_pkg::item_type   head_item,
   output tpgoc_pkg::q_stat_type stat
);
   import tpgoc_pkg::*;

   item_type                 entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_item;
   end

   assign head_item  = entries_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

/* rtl/tpgoc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with lanes sharing a divisor.
module tpgoc_div #(
   parameter int L = 1,
   parameter int N = 32,
   parameter int D = 16,
   parameter int W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [L-1:0][N-1:0] in_num,
   input  logic [D-1:0]        in_den,
   input  logic [W-1:0]        in_ctx,
   output logic                out_valid,
   output logic [L-1:0][N-1:0] out_quo,
   output logic [W-1:0]        out_ctx
);

   logic                valid_ff [N];
   logic [L-1:0][N-1:0] num_ff   [N];
   logic [L-1:0][D-1:0] rem_ff   [N];
   logic [D-1:0]        den_ff   [N];
   logic [W-1:0]        ctx_ff   [N];

   logic                vld_src  [N];
   logic [L-1:0][N-1:0] num_src  [N];
   logic [L-1:0][D-1:0] rem_src  [N];
   logic [D-1:0]        den_src  [N];
   logic [W-1:0]        ctx_src  [N];

   logic [L-1:0][N-1:0] num_in   [N];
   logic [L-1:0][D-1:0] rem_in   [N];

   for (genvar s = 0; s < N; s++) begin : g_stage
      // Stage inputs come from the ports or from the previous stage.
      if (s == 0) begin : g_first
         assign vld_src[s] = in_valid;
         assign num_src[s] = in_num;
         assign rem_src[s] = '0;
         assign den_src[s] = in_den;
         assign ctx_src[s] = in_ctx;
      end else begin : g_next
         assign vld_src[s] = valid_ff[s-1];
         assign num_src[s] = num_ff[s-1];
         assign rem_src[s] = rem_ff[s-1];
         assign den_src[s] = den_ff[s-1];
         assign ctx_src[s] = ctx_ff[s-1];
      end

      // One trial subtraction per lane.
      always_comb begin
         logic [D:0] part;
         logic       qb;
         for (int l = 0; l < L; l++) begin
            part = {rem_src[s][l], num_src[s][l][N-1]};
            if (part >= {1'b0, den_src[s]}) begin
               part = part - {1'b0, den_src[s]};
               qb   = 1'b1;
            end else begin
               qb   = 1'b0;
            end
            rem_in[s][l] = part[D-1:0];
            num_in[s][l] = {num_src[s][l][N-2:0], qb};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= vld_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[s] <= num_in[s];
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_src[s];
            ctx_ff[s] <= ctx_src[s];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quo   = num_ff[N-1];
   assign out_ctx   = ctx_ff[N-1];

endmodule

/* rtl/tpgoc_back.sv */
// Correction datapath: x and y interpolation through multipliers and pipelined dividers.
module tpgoc_back #(
   parameter int DISPLAY_WIDTH  = 1080,
   parameter int DISPLAY_HEIGHT = 1920
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  tpgoc_pkg::item_type in_item,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tpgoc_pkg::rsp_type  rsp_data
);
   import tpgoc_pkg::*;

   localparam int CW = $bits(ctx_type);

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   // The whole datapath moves when the output register can take a request.
   assign advance = !rsp_valid_ff || rsp_ready;

   // Stage 1: x offset slope products for the top and bottom corner pairs.
   logic               v1_ff;
   ctx_type            c1_ff, c1_in;
   logic [1:0][31:0]   mag1_ff, mag1_in;
   logic [15:0]        den1_ff, den1_in;

   always_comb begin
      logic signed [16:0] dt, db;
      logic signed [33:0] pt, pb;
      logic [49:0]        mt, mb;
      c1_in    = '0;
      c1_in.it = in_item;
      dt = 17'($signed(in_item.ox[1])) - 17'($signed(in_item.ox[0]));
      db = 17'($signed(in_item.ox[3])) - 17'($signed(in_item.ox[2]));
      pt = 34'(dt) * 34'(in_item.nx);
      pb = 34'(db) * 34'(in_item.nx);
      mt = mag50(50'(pt));
      mb = mag50(50'(pb));
      mag1_in[0]    = mt[31:0];
      mag1_in[1]    = mb[31:0];
      c1_in.qneg[0] = pt[33] ^ in_item.sx[16];
      c1_in.qneg[1] = pb[33] ^ in_item.sx[16];
      den1_in       = mag17(in_item.sx);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff   <= c1_in;
         mag1_ff <= mag1_in;
         den1_ff <= den1_in;
      end
   end

   logic               va;
   logic [1:0][31:0]   qa;
   ctx_type            ca;

   tpgoc_div #(.L(2), .N(32), .D(16), .W(CW)) u_div_xa (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v1_ff),
      .in_num    (mag1_ff),
      .in_den    (den1_ff),
      .in_ctx    (c1_ff),
      .out_valid (va),
      .out_quo   (qa),
      .out_ctx   (ca)
   );

   // Stage 2: x offsets along the top and bottom edges of the area.
   logic               v2_ff;
   ctx_type            c2_ff, c2_in;

   always_comb begin
      c2_in = ca;
      if (ca.it.sx == 17'sd0) begin
         c2_in.pq = 32'($signed(ca.it.ox[0]));
         c2_in.rs = 32'($signed(ca.it.ox[2]));
      end else begin
         c2_in.pq = sat32(apply_sign(ca.qneg[0], 48'(qa[0])) + 50'($signed(ca.it.ox[0])));
         c2_in.rs = sat32(apply_sign(ca.qneg[1], 48'(qa[1])) + 50'($signed(ca.it.ox[2])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= va;
   end

   always_ff @(posedge clock) begin
      if (advance) c2_ff <= c2_in;
   end

   // Stage 3: vertical slope product for the x offset.
   logic               v3_ff;
   ctx_type            c3_ff, c3_in;
   logic [0:0][47:0]   mag3_ff, mag3_in;
   logic [15:0]        den3_ff, den3_in;

   always_comb begin
      logic signed [32:0] d;
      logic signed [49:0] p;
      logic [49:0]        m;
      c3_in = c2_ff;
      d = 33'(c2_ff.rs) - 33'(c2_ff.pq);
      p = 50'(d) * 50'(c2_ff.it.ny);
      m = mag50(p);
      mag3_in[0]    = m[47:0];
      c3_in.qneg[0] = p[49] ^ c2_ff.it.sy[16];
      den3_in       = mag17(c2_ff.it.sy);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_ff   <= c3_in;
         mag3_ff <= mag3_in;
         den3_ff <= den3_in;
      end
   end

   logic               vb;
   logic [0:0][47:0]   qb;
   ctx_type            cb;

   tpgoc_div #(.L(1), .N(48), .D(16), .W(CW)) u_div_xt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v3_ff),
      .in_num    (mag3_ff),
      .in_den    (den3_ff),
      .in_ctx    (c3_ff),
      .out_valid (vb),
      .out_quo   (qb),
      .out_ctx   (cb)
   );

   // Stage 4: interpolated x offset and corrected x.
   logic               v4_ff;
   ctx_type            c4_ff, c4_in;

   always_comb begin
      logic signed [31:0] t;
      c4_in = cb;
      if (cb.it.sy == 17'sd0) begin
         t = cb.pq;
      end else begin
         t = sat32(apply_sign(cb.qneg[0], qb[0]) + 50'(cb.pq));
      end
      c4_in.cx = sat32(50'($signed({1'b0, cb.it.x})) - 50'(t));
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= vb;
   end

   always_ff @(posedge clock) begin
      if (advance) c4_ff <= c4_in;
   end

   // Stage 5: distance of the corrected x from the area's left bound.
   logic               v5_ff;
   ctx_type            c5_ff;
   logic signed [32:0] ncx5_ff, ncx5_in;

   assign ncx5_in = 33'(c4_ff.cx) - 33'($signed({1'b0, c4_ff.it.bxp}));

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (advance) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c5_ff   <= c4_ff;
         ncx5_ff <= ncx5_in;
      end
   end

   // Stage 6: y offset slope products along the top and bottom edges.
   logic               v6_ff;
   ctx_type            c6_ff, c6_in;
   logic [1:0][47:0]   mag6_ff, mag6_in;
   logic [15:0]        den6_ff, den6_in;

   always_comb begin
      logic signed [16:0] dt, db;
      logic signed [49:0] pt, pb;
      logic [49:0]        mt, mb;
      c6_in = c5_ff;
      dt = 17'($signed(c5_ff.it.oy[1])) - 17'($signed(c5_ff.it.oy[0]));
      db = 17'($signed(c5_ff.it.oy[3])) - 17'($signed(c5_ff.it.oy[2]));
      pt = 50'(dt) * 50'(ncx5_ff);
      pb = 50'(db) * 50'(ncx5_ff);
      mt = mag50(pt);
      mb = mag50(pb);
      mag6_in[0]    = mt[47:0];
      mag6_in[1]    = mb[47:0];
      c6_in.qneg[0] = pt[49] ^ c5_ff.it.sx[16];
      c6_in.qneg[1] = pb[49] ^ c5_ff.it.sx[16];
      den6_in       = mag17(c5_ff.it.sx);
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (advance) v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c6_ff   <= c6_in;
         mag6_ff <= mag6_in;
         den6_ff <= den6_in;
      end
   end

   logic               vc;
   logic [1:0][47:0]   qc;
   ctx_type            cc;

   tpgoc_div #(.L(2), .N(48), .D(16), .W(CW)) u_div_ya (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v6_ff),
      .in_num    (mag6_ff),
      .in_den    (den6_ff),
      .in_ctx    (c6_ff),
      .out_valid (vc),
      .out_quo   (qc),
      .out_ctx   (cc)
   );

   // Stage 7: y offsets along the top and bottom edges of the area.
   logic               v7_ff;
   ctx_type            c7_ff, c7_in;

   always_comb begin
      c7_in = cc;
      if (cc.it.sx == 17'sd0) begin
         c7_in.pq = 32'($signed(cc.it.oy[0]));
         c7_in.rs = 32'($signed(cc.it.oy[2]));
      end else begin
         c7_in.pq = sat32(apply_sign(cc.qneg[0], qc[0]) + 50'($signed(cc.it.oy[0])));
         c7_in.rs = sat32(apply_sign(cc.qneg[1], qc[1]) + 50'($signed(cc.it.oy[2])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (advance) v7_ff <= vc;
   end

   always_ff @(posedge clock) begin
      if (advance) c7_ff <= c7_in;
   end

   // Stage 8: vertical slope product for the y offset.
   logic               v8_ff;
   ctx_type            c8_ff, c8_in;
   logic [0:0][47:0]   mag8_ff, mag8_in;
   logic [15:0]        den8_ff, den8_in;

   always_comb begin
      logic signed [32:0] d;
      logic signed [49:0] p;
      logic [49:0]        m;
      c8_in = c7_ff;
      d = 33'(c7_ff.rs) - 33'(c7_ff.pq);
      p = 50'(d) * 50'(c7_ff.it.ny);
      m = mag50(p);
      mag8_in[0]    = m[47:0];
      c8_in.qneg[0] = p[49] ^ c7_ff.it.sy[16];
      den8_in       = mag17(c7_ff.it.sy);
   end

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (advance) v8_ff <= v7_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c8_ff   <= c8_in;
         mag8_ff <= mag8_in;
         den8_ff <= den8_in;
      end
   end

   logic               vd;
   logic [0:0][47:0]   qd;
   ctx_type            cd;

   tpgoc_div #(.L(1), .N(48), .D(16), .W(CW)) u_div_yt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v8_ff),
      .in_num    (mag8_ff),
      .in_den    (den8_ff),
      .in_ctx    (c8_ff),
      .out_valid (vd),
      .out_quo   (qd),
      .out_ctx   (cd)
   );

   // Stage 9: interpolated y offset.
   logic               v9_ff;
   ctx_type            c9_ff, c9_in;

   always_comb begin
      c9_in = cd;
      if (cd.it.sy == 17'sd0) begin
         c9_in.ty = cd.pq;
      end else begin
         c9_in.ty = sat32(apply_sign(cd.qneg[0], qd[0]) + 50'(cd.pq));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (advance) v9_ff <= vd;
   end

   always_ff @(posedge clock) begin
      if (advance) c9_ff <= c9_in;
   end

   // Output register: corrected y, clamping to the display, or pass-through.
   always_comb begin
      logic signed [31:0] cy;
      logic signed [31:0] cx;
      cx = c9_ff.cx;
      cy = sat32(50'($signed({1'b0, c9_ff.it.y})) - 50'(c9_ff.ty));
      if (cx >= $signed({16'd0, 16'(DISPLAY_WIDTH)})) cx = $signed({16'd0, 16'(DISPLAY_WIDTH - 1)});
      if (cx < 32'sd0) cx = 32'sd0;
      if (cy >= $signed({16'd0, 16'(DISPLAY_HEIGHT)})) cy = $signed({16'd0, 16'(DISPLAY_HEIGHT - 1)});
      if (cy < 32'sd0) cy = 32'sd0;
      if (c9_ff.it.pass) begin
         rsp_in.x_out     = c9_ff.it.x;
         rsp_in.y_out     = c9_ff.it.y;
         rsp_in.corrected = 1'b0;
      end else begin
         rsp_in.x_out     = cx[15:0];
         rsp_in.y_out     = cy[15:0];
         rsp_in.corrected = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= v9_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
